// File: rtl/core/rotation_matrix_to_quaternion_defines.svh
// assertion macros shared by the rotation matrix to quaternion rtl
`ifndef ROTATION_MATRIX_TO_QUATERNION_DEFINES_SVH
`define ROTATION_MATRIX_TO_QUATERNION_DEFINES_SVH

// same-cycle implication, sampled on clk, off during rst
`define RMQ_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define RMQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/rmq_pkg.sv
`default_nettype none

package rmq_pkg;

  localparam int DW            = 16;
  localparam int NUM_W         = 17;
  localparam int QBITS         = 18;
  localparam int FRAC_BITS_DEF = 14;
  localparam int QMAX_I        = 32767;
  localparam int QMIN_MAG_I    = 32768;

  localparam logic signed [DW-1:0] QMAX = 16'sh7fff;
  localparam logic signed [DW-1:0] QMIN = 16'sh8000;

  // sign extend one matrix element by one bit
  function automatic logic signed [NUM_W-1:0] sx17(input logic signed [DW-1:0] v);
    sx17 = {v[DW-1], v};
  endfunction

  // signed, saturated result from a quotient magnitude
  function automatic logic signed [DW-1:0] sat16(input logic neg, input logic nz,
                                                 input logic [QBITS-1:0] q);
    logic signed [DW-1:0] r;
    if (!nz) begin
      r = '0;
    end else if (!neg) begin
      r = (q > QBITS'(QMAX_I)) ? QMAX : DW'(q);
    end else begin
      r = (q > QBITS'(QMIN_MAG_I)) ? QMIN : -DW'(q);
    end
    sat16 = r;
  endfunction

  // negation that maps the most negative code to the most positive
  function automatic logic signed [DW-1:0] neg_sat(input logic signed [DW-1:0] v);
    neg_sat = (v == QMIN) ? QMAX : -v;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/rmq_if.sv
`default_nettype none

// matrix word channel
interface rmq_mat_if import rmq_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic signed [DW-1:0] m00;
  logic signed [DW-1:0] m01;
  logic signed [DW-1:0] m02;
  logic signed [DW-1:0] m10;
  logic signed [DW-1:0] m11;
  logic signed [DW-1:0] m12;
  logic signed [DW-1:0] m20;
  logic signed [DW-1:0] m21;
  logic signed [DW-1:0] m22;
  modport source(output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22, input ready);
  modport sink(input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22, output ready);
endinterface

// quaternion word channel
interface rmq_quat_if import rmq_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic signed [DW-1:0] q_w;
  logic signed [DW-1:0] q_x;
  logic signed [DW-1:0] q_y;
  logic signed [DW-1:0] q_z;
  modport source(output valid, q_w, q_x, q_y, q_z, input ready);
  modport sink(input valid, q_w, q_x, q_y, q_z, output ready);
endinterface

// mode register write channel
interface rmq_cfg_if;
  logic valid;
  logic ready;
  logic force_positive_scalar;
  modport source(output valid, force_positive_scalar, input ready);
  modport sink(input valid, force_positive_scalar, output ready);
endinterface

`default_nettype wire

// File: rtl/core/rotation_matrix_to_quaternion.sv
// throughput: one matrix word per cycle; the whole pipeline advances together
// and holds while the output register is full and not taken
// reset: rst is synchronous and active high, clears all stage valid bits and
// sets force_positive_scalar to 1
`default_nettype none
`include "rotation_matrix_to_quaternion_defines.svh"

module rotation_matrix_to_quaternion
  import rmq_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  rmq_mat_if.sink       mat,
  rmq_quat_if.source    quat,
  rmq_cfg_if.sink       cfg
);

  typedef enum logic [1:0] {BR_T, BR_X, BR_Y, BR_Z} branch_t;

  localparam int RAD_W = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 2;
  localparam int UR_W  = RAD_W - 1;
  localparam int SR1_N = (UR_W + FRAC_BITS + 1) / 2;
  localparam int SQ1_W = 2 * SR1_N;
  localparam int R1_W  = SR1_N + 2;
  localparam int S1_W  = SR1_N + 1;
  localparam int A1_W  = NUM_W + FRAC_BITS;
  localparam int D1_W  = (A1_W > S1_W + QBITS) ? A1_W : S1_W + QBITS;
  localparam int SQW   = 2 * DW - 1;
  localparam int N2_W  = SQW + 2;
  localparam int SR2_N = (N2_W + 1) / 2;
  localparam int SQ2_W = 2 * SR2_N;
  localparam int R2_W  = SR2_N + 2;
  localparam int A2_W  = DW + FRAC_BITS;
  localparam int D2_W  = (A2_W > SR2_N + QBITS) ? A2_W : SR2_N + QBITS;
  localparam logic [RAD_W-1:0] ONE_R = RAD_W'(1) << FRAC_BITS;

  logic adv;
  logic force_pos;

  // mode register
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      force_pos <= 1'b1;
    end else if (cfg.valid) begin
      force_pos <= cfg.force_positive_scalar;
    end
  end

  // ---------------- stage a: branch, radicand, numerators
  logic signed [RAD_W-1:0] e00, e11, e22, tr, rad_nx;
  logic signed [NUM_W-1:0] d_w, d_y, d_z, s_xy, s_xz, s_yz;
  logic signed [NUM_W-1:0] num_nx [3];
  branch_t                 br_nx;

  always_comb begin
    e00 = RAD_W'(mat.m00);
    e11 = RAD_W'(mat.m11);
    e22 = RAD_W'(mat.m22);
    tr  = e00 + e11 + e22;
    if (tr > 0) begin
      br_nx  = BR_T;
      rad_nx = $signed(ONE_R) + tr;
    end else if (mat.m00 > mat.m11 && mat.m00 > mat.m22) begin
      br_nx  = BR_X;
      rad_nx = $signed(ONE_R) + e00 - e11 - e22;
    end else if (mat.m11 > mat.m22) begin
      br_nx  = BR_Y;
      rad_nx = $signed(ONE_R) + e11 - e00 - e22;
    end else begin
      br_nx  = BR_Z;
      rad_nx = $signed(ONE_R) + e22 - e00 - e11;
    end
    d_w  = sx17(mat.m21) - sx17(mat.m12);
    d_y  = sx17(mat.m02) - sx17(mat.m20);
    d_z  = sx17(mat.m10) - sx17(mat.m01);
    s_xy = sx17(mat.m01) + sx17(mat.m10);
    s_xz = sx17(mat.m02) + sx17(mat.m20);
    s_yz = sx17(mat.m12) + sx17(mat.m21);
    // non-pivot numerators in component order
    case (br_nx)
      BR_T: begin
        num_nx[0] = d_w;  num_nx[1] = d_y;  num_nx[2] = d_z;
      end
      BR_X: begin
        num_nx[0] = d_w;  num_nx[1] = s_xy; num_nx[2] = s_xz;
      end
      BR_Y: begin
        num_nx[0] = d_y;  num_nx[1] = s_xy; num_nx[2] = s_yz;
      end
      BR_Z: begin
        num_nx[0] = d_z;  num_nx[1] = s_xz; num_nx[2] = s_yz;
      end
      default: begin
        num_nx[0] = d_w;  num_nx[1] = d_y;  num_nx[2] = d_z;
      end
    endcase
  end

  logic                    a_valid;
  branch_t                 a_br;
  logic signed [RAD_W-1:0] a_rad;
  logic signed [NUM_W-1:0] a_num [3];

  assign mat.ready = adv;

  always_ff @(posedge clk) begin
    if (rst) a_valid <= 1'b0;
    else if (adv) a_valid <= mat.valid;
    if (adv) begin
      a_br  <= br_nx;
      a_rad <= rad_nx;
      a_num <= num_nx;
    end
  end

  // ---------------- first square root, one root bit per stage
  logic [SQ1_W-1:0] s1_x_in;
  assign s1_x_in = (a_rad > 0) ? (SQ1_W'(a_rad[UR_W-1:0]) << FRAC_BITS) : '0;

  logic                    s1_valid [SR1_N];
  branch_t                 s1_br    [SR1_N];
  logic [R1_W-1:0]         s1_rem   [SR1_N];
  logic [SR1_N-1:0]        s1_root  [SR1_N];
  logic [SQ1_W-1:0]        s1_x     [SR1_N];
  logic signed [NUM_W-1:0] s1_num   [SR1_N][3];

  for (genvar k = 0; k < SR1_N; k++) begin : g_sq1
    logic                    v_i;
    branch_t                 br_i;
    logic [R1_W-1:0]         rem_i, rem_o;
    logic [SR1_N-1:0]        root_i, root_o;
    logic [SQ1_W-1:0]        x_i;
    logic [R1_W+1:0]         rem2, trial;
    logic signed [NUM_W-1:0] num_i [3];

    if (k == 0) begin : g_first
      always_comb begin
        v_i = a_valid; br_i = a_br; rem_i = '0; root_i = '0;
        x_i = s1_x_in; num_i = a_num;
      end
    end else begin : g_next
      always_comb begin
        v_i = s1_valid[k-1]; br_i = s1_br[k-1]; rem_i = s1_rem[k-1];
        root_i = s1_root[k-1]; x_i = s1_x[k-1]; num_i = s1_num[k-1];
      end
    end

    // trial subtract of the next two radicand bits
    always_comb begin
      rem2  = {rem_i, x_i[SQ1_W-1 -: 2]};
      trial = (R1_W+2)'({root_i, 2'b01});
      if (rem2 >= trial) begin
        rem_o  = R1_W'(rem2 - trial);
        root_o = {root_i[SR1_N-2:0], 1'b1};
      end else begin
        rem_o  = R1_W'(rem2);
        root_o = {root_i[SR1_N-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) s1_valid[k] <= 1'b0;
      else if (adv) s1_valid[k] <= v_i;
      if (adv) begin
        s1_br[k]   <= br_i;
        s1_rem[k]  <= rem_o;
        s1_root[k] <= root_o;
        s1_x[k]    <= x_i << 2;
        s1_num[k]  <= num_i;
      end
    end
  end

  // ---------------- first divider entry: S, pivot, magnitudes
  localparam int L1 = SR1_N - 1;

  logic [S1_W-1:0]  d1_s_in;
  logic [SR1_N-1:0] half_root;
  logic [DW-1:0]    d1_piv_in;
  logic [D1_W-1:0]  d1_a_in [3];
  logic             d1_neg_in [3];
  logic             d1_nz_in [3];
  logic [NUM_W-1:0] mag1 [3];

  always_comb begin
    d1_s_in   = {s1_root[L1], 1'b0};
    half_root = s1_root[L1] >> 1;
    d1_piv_in = (half_root > (SR1_N+16)'(QMAX_I)) ? DW'(QMAX) : DW'(half_root);
    for (int j = 0; j < 3; j++) begin
      d1_neg_in[j] = s1_num[L1][j] < 0;
      d1_nz_in[j]  = s1_num[L1][j] != 0;
      mag1[j]      = NUM_W'(d1_neg_in[j] ? -s1_num[L1][j] : s1_num[L1][j]);
      d1_a_in[j]   = D1_W'(mag1[j]) << FRAC_BITS;
    end
  end

  // ---------------- first divider, one quotient bit per stage, three lanes
  logic             d1_valid [QBITS];
  branch_t          d1_br    [QBITS];
  logic [DW-1:0]    d1_piv   [QBITS];
  logic [S1_W-1:0]  d1_s     [QBITS];
  logic             d1_neg   [QBITS][3];
  logic             d1_nz    [QBITS][3];
  logic [D1_W-1:0]  d1_rem   [QBITS][3];
  logic [QBITS-1:0] d1_q     [QBITS][3];

  for (genvar k = 0; k < QBITS; k++) begin : g_div1
    localparam int B = QBITS - 1 - k;
    logic             v_i;
    branch_t          br_i;
    logic [DW-1:0]    piv_i;
    logic [S1_W-1:0]  s_i;
    logic             neg_i [3];
    logic             nz_i  [3];
    logic [D1_W-1:0]  rem_i [3];
    logic [D1_W-1:0]  rem_o [3];
    logic [QBITS-1:0] q_i   [3];
    logic [QBITS-1:0] q_o   [3];
    logic [D1_W-1:0]  cmp;

    if (k == 0) begin : g_first
      always_comb begin
        v_i = s1_valid[L1]; br_i = s1_br[L1]; piv_i = d1_piv_in; s_i = d1_s_in;
        neg_i = d1_neg_in; nz_i = d1_nz_in; rem_i = d1_a_in;
        for (int j = 0; j < 3; j++) q_i[j] = '0;
      end
    end else begin : g_next
      always_comb begin
        v_i = d1_valid[k-1]; br_i = d1_br[k-1]; piv_i = d1_piv[k-1]; s_i = d1_s[k-1];
        neg_i = d1_neg[k-1]; nz_i = d1_nz[k-1]; rem_i = d1_rem[k-1]; q_i = d1_q[k-1];
      end
    end

    // restoring step against S shifted to this bit
    always_comb begin
      cmp = D1_W'(s_i) << B;
      for (int j = 0; j < 3; j++) begin
        if (rem_i[j] >= cmp) begin
          rem_o[j] = rem_i[j] - cmp;
          q_o[j]   = {q_i[j][QBITS-2:0], 1'b1};
        end else begin
          rem_o[j] = rem_i[j];
          q_o[j]   = {q_i[j][QBITS-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) d1_valid[k] <= 1'b0;
      else if (adv) d1_valid[k] <= v_i;
      if (adv) begin
        d1_br[k]  <= br_i;
        d1_piv[k] <= piv_i;
        d1_s[k]   <= s_i;
        d1_neg[k] <= neg_i;
        d1_nz[k]  <= nz_i;
        d1_rem[k] <= rem_o;
        d1_q[k]   <= q_o;
      end
    end
  end

  // ---------------- stage c: saturate and place the pivot
  localparam int LD = QBITS - 1;

  logic signed [DW-1:0] r1 [3];
  logic signed [DW-1:0] c_nx [4];

  always_comb begin
    for (int j = 0; j < 3; j++) r1[j] = sat16(d1_neg[LD][j], d1_nz[LD][j], d1_q[LD][j]);
    case (d1_br[LD])
      BR_T: begin
        c_nx[0] = d1_piv[LD]; c_nx[1] = r1[0]; c_nx[2] = r1[1]; c_nx[3] = r1[2];
      end
      BR_X: begin
        c_nx[0] = r1[0]; c_nx[1] = d1_piv[LD]; c_nx[2] = r1[1]; c_nx[3] = r1[2];
      end
      BR_Y: begin
        c_nx[0] = r1[0]; c_nx[1] = r1[1]; c_nx[2] = d1_piv[LD]; c_nx[3] = r1[2];
      end
      BR_Z: begin
        c_nx[0] = r1[0]; c_nx[1] = r1[1]; c_nx[2] = r1[2]; c_nx[3] = d1_piv[LD];
      end
      default: begin
        c_nx[0] = d1_piv[LD]; c_nx[1] = r1[0]; c_nx[2] = r1[1]; c_nx[3] = r1[2];
      end
    endcase
  end

  logic                 c_valid;
  logic signed [DW-1:0] c_q [4];

  always_ff @(posedge clk) begin
    if (rst) c_valid <= 1'b0;
    else if (adv) c_valid <= d1_valid[LD];
    if (adv) c_q <= c_nx;
  end

  // ---------------- stage d: squares
  logic signed [2*DW-1:0] prod [4];
  logic                   d_valid;
  logic [SQW-1:0]         d_sq [4];
  logic signed [DW-1:0]   d_q  [4];

  always_comb begin
    for (int i = 0; i < 4; i++) prod[i] = c_q[i] * c_q[i];
  end

  always_ff @(posedge clk) begin
    if (rst) d_valid <= 1'b0;
    else if (adv) d_valid <= c_valid;
    if (adv) begin
      for (int i = 0; i < 4; i++) d_sq[i] <= prod[i][SQW-1:0];
      d_q <= c_q;
    end
  end

  // ---------------- stage e: sum of squares
  logic                 e_valid;
  logic [N2_W-1:0]      e_n2;
  logic signed [DW-1:0] e_q [4];

  always_ff @(posedge clk) begin
    if (rst) e_valid <= 1'b0;
    else if (adv) e_valid <= d_valid;
    if (adv) begin
      e_n2 <= N2_W'(d_sq[0]) + N2_W'(d_sq[1]) + N2_W'(d_sq[2]) + N2_W'(d_sq[3]);
      e_q  <= d_q;
    end
  end

  // ---------------- second square root: the norm
  logic                 s2_valid [SR2_N];
  logic [R2_W-1:0]      s2_rem   [SR2_N];
  logic [SR2_N-1:0]     s2_root  [SR2_N];
  logic [SQ2_W-1:0]     s2_x     [SR2_N];
  logic signed [DW-1:0] s2_q     [SR2_N][4];

  for (genvar k = 0; k < SR2_N; k++) begin : g_sq2
    logic                 v_i;
    logic [R2_W-1:0]      rem_i, rem_o;
    logic [SR2_N-1:0]     root_i, root_o;
    logic [SQ2_W-1:0]     x_i;
    logic [R2_W+1:0]      rem2, trial;
    logic signed [DW-1:0] q_i [4];

    if (k == 0) begin : g_first
      always_comb begin
        v_i = e_valid; rem_i = '0; root_i = '0; x_i = SQ2_W'(e_n2); q_i = e_q;
      end
    end else begin : g_next
      always_comb begin
        v_i = s2_valid[k-1]; rem_i = s2_rem[k-1]; root_i = s2_root[k-1];
        x_i = s2_x[k-1]; q_i = s2_q[k-1];
      end
    end

    // trial subtract of the next two bits
    always_comb begin
      rem2  = {rem_i, x_i[SQ2_W-1 -: 2]};
      trial = (R2_W+2)'({root_i, 2'b01});
      if (rem2 >= trial) begin
        rem_o  = R2_W'(rem2 - trial);
        root_o = {root_i[SR2_N-2:0], 1'b1};
      end else begin
        rem_o  = R2_W'(rem2);
        root_o = {root_i[SR2_N-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) s2_valid[k] <= 1'b0;
      else if (adv) s2_valid[k] <= v_i;
      if (adv) begin
        s2_rem[k]  <= rem_o;
        s2_root[k] <= root_o;
        s2_x[k]    <= x_i << 2;
        s2_q[k]    <= q_i;
      end
    end
  end

  // ---------------- second divider entry
  localparam int L2 = SR2_N - 1;

  logic [D2_W-1:0] d2_a_in   [4];
  logic            d2_neg_in [4];
  logic            d2_nz_in  [4];
  logic [DW-1:0]   mag2      [4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      d2_neg_in[i] = s2_q[L2][i] < 0;
      d2_nz_in[i]  = s2_q[L2][i] != 0;
      mag2[i]      = DW'(d2_neg_in[i] ? -s2_q[L2][i] : s2_q[L2][i]);
      d2_a_in[i]   = D2_W'(mag2[i]) << FRAC_BITS;
    end
  end

  // ---------------- second divider, four lanes over the norm
  logic             d2_valid [QBITS];
  logic [SR2_N-1:0] d2_norm  [QBITS];
  logic             d2_zero  [QBITS];
  logic             d2_neg   [QBITS][4];
  logic             d2_nz    [QBITS][4];
  logic [D2_W-1:0]  d2_rem   [QBITS][4];
  logic [QBITS-1:0] d2_q     [QBITS][4];

  for (genvar k = 0; k < QBITS; k++) begin : g_div2
    localparam int B = QBITS - 1 - k;
    logic             v_i;
    logic [SR2_N-1:0] norm_i;
    logic             zero_i;
    logic             neg_i [4];
    logic             nz_i  [4];
    logic [D2_W-1:0]  rem_i [4];
    logic [D2_W-1:0]  rem_o [4];
    logic [QBITS-1:0] q_i   [4];
    logic [QBITS-1:0] q_o   [4];
    logic [D2_W-1:0]  cmp;

    if (k == 0) begin : g_first
      always_comb begin
        v_i = s2_valid[L2]; norm_i = s2_root[L2]; zero_i = (s2_root[L2] == '0);
        neg_i = d2_neg_in; nz_i = d2_nz_in; rem_i = d2_a_in;
        for (int i = 0; i < 4; i++) q_i[i] = '0;
      end
    end else begin : g_next
      always_comb begin
        v_i = d2_valid[k-1]; norm_i = d2_norm[k-1]; zero_i = d2_zero[k-1];
        neg_i = d2_neg[k-1]; nz_i = d2_nz[k-1]; rem_i = d2_rem[k-1]; q_i = d2_q[k-1];
      end
    end

    // restoring step against the norm shifted to this bit
    always_comb begin
      cmp = D2_W'(norm_i) << B;
      for (int i = 0; i < 4; i++) begin
        if (rem_i[i] >= cmp) begin
          rem_o[i] = rem_i[i] - cmp;
          q_o[i]   = {q_i[i][QBITS-2:0], 1'b1};
        end else begin
          rem_o[i] = rem_i[i];
          q_o[i]   = {q_i[i][QBITS-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) d2_valid[k] <= 1'b0;
      else if (adv) d2_valid[k] <= v_i;
      if (adv) begin
        d2_norm[k] <= norm_i;
        d2_zero[k] <= zero_i;
        d2_neg[k]  <= neg_i;
        d2_nz[k]   <= nz_i;
        d2_rem[k]  <= rem_o;
        d2_q[k]    <= q_o;
      end
    end
  end

  // ---------------- output stage: saturate, sign fold, output register
  logic signed [DW-1:0] r2   [4];
  logic signed [DW-1:0] o_nx [4];
  logic                 flip;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      r2[i] = d2_zero[LD] ? '0 : sat16(d2_neg[LD][i], d2_nz[LD][i], d2_q[LD][i]);
    end
    flip = force_pos && r2[0][DW-1];
    for (int i = 0; i < 4; i++) o_nx[i] = flip ? neg_sat(r2[i]) : r2[i];
  end

  logic                 o_valid;
  logic signed [DW-1:0] o_q [4];

  assign adv        = !o_valid || quat.ready;
  assign quat.valid = o_valid;
  assign quat.q_w   = o_q[0];
  assign quat.q_x   = o_q[1];
  assign quat.q_y   = o_q[2];
  assign quat.q_z   = o_q[3];

  always_ff @(posedge clk) begin
    if (rst) o_valid <= 1'b0;
    else if (adv) o_valid <= d2_valid[LD];
    if (adv) o_q <= o_nx;
  end

  // ---------------- checks
  `RMQ_ASSERT_NEXT(a_word_enters, mat.valid && mat.ready, a_valid, "accepted word lost at entry")
  `RMQ_ASSERT_NEXT(a_stall_holds, a_valid && !adv, a_valid, "first stage dropped a word in stall")
  `RMQ_ASSERT_IMPL(a_scalar_sign, quat.valid && force_pos, !quat.q_w[DW-1], "negative scalar part")

endmodule

`default_nettype wire
